>>> rtl/mlp_pkg.sv
package mlp_pkg;

    localparam int OUT_FRAC_DEF = 14;
    localparam int HID_FRAC     = 16;
    localparam int LANES        = 4;
    localparam int DIST_W       = 10;
    localparam int ANG_W        = 8;
    localparam int OUT_W        = 16;
    localparam int W_BITS       = 20;
    localparam int X_W          = 32;
    localparam int H_W          = HID_FRAC + 2;
    localparam int ANG_TERM_W   = 18;

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic [ANG_W-1:0]  servo_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] drive_out0;
        logic signed [OUT_W-1:0] drive_out1;
        logic signed [OUT_W-1:0] drive_out2;
        logic signed [OUT_W-1:0] drive_out3;
    } t_out_item;

    typedef logic signed [X_W-1:0] t_x_vec [LANES];

    typedef logic signed [ANG_TERM_W-1:0] t_ang_tab [256];

    // hidden layer weights, Q.16: row 0 bias, row 1 distance, row 2 angle
    localparam logic signed [W_BITS-1:0] HID_W [3][LANES] = '{
        '{ 20'sd124463, -20'sd31257,  -20'sd42492,  -20'sd25303},
        '{-20'sd18472,   20'sd262845,  20'sd211628, -20'sd189681},
        '{ 20'sd21893,  -20'sd91856,   20'sd88998,  -20'sd64318}
    };

    // output layer weights, Q.16, indexed [hidden unit][output unit]
    localparam logic signed [W_BITS-1:0] OUT_WT [LANES][LANES] = '{
        '{ 20'sd74454,   20'sd101320,  20'sd106133,  20'sd123333},
        '{-20'sd101382,  20'sd91435,   20'sd12710,   20'sd20311},
        '{-20'sd50830,   20'sd61544,   20'sd136725, -20'sd73594},
        '{-20'sd80983,   20'sd56256,   20'sd47494,   20'sd64070}
    };

    // angle term per servo angle, built at elaboration
    function automatic t_ang_tab build_ang_tab();
        t_ang_tab tab;
        int m;
        int r;
        for (int i = 0; i < 256; i++) begin
            m = -(((i - 215) * 200) / 180) - 100;
            if (m > 100) m = 100;
            if (m < -100) m = -100;
            if (m >= 0) r = (m * 65536 + 50) / 100;
            else r = -((-m * 65536 + 50) / 100);
            tab[i] = r[ANG_TERM_W-1:0];
        end
        return tab;
    endfunction

    localparam t_ang_tab ANG_TAB = build_ang_tab();

endpackage

>>> rtl/tiny_mlp_tanh_inference_core.sv
// channel   direction  valid        stall         payload
// input     in         i_in_valid   o_in_stall    i_in_data  (t_in_item)
// output    out        o_out_valid  i_out_stall   o_out_data (t_out_item)
//
// one item per cycle while the skid register is empty; most of the pipeline is
// the two tanh pipelines and their one-bit-per-stage dividers
// reset clears all valid bits and the tanh sign and saturation flags; other payload registers are not reset
// a stalled output parks one result in a skid register, input stall is that
// register's full flag, and the whole pipeline holds while it is full
module tiny_mlp_tanh_inference_core #(
    parameter int OUT_FRAC_BITS = mlp_pkg::OUT_FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mlp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mlp_pkg::t_out_item o_out_data
);
    import mlp_pkg::*;

    logic                          w_en;
    logic                          w_take;
    logic                          w_hx_valid;
    t_x_vec                        w_hx;
    logic                          w_hy_valid;
    logic signed [H_W-1:0]         w_hy [LANES];
    logic                          w_ox_valid;
    t_x_vec                        w_ox;
    logic                          w_pipe_valid;
    logic signed [OUT_FRAC_BITS+1:0] w_oy [LANES];
    logic signed [OUT_W-1:0]       w_sat [LANES];
    t_out_item                     w_pipe_data;
    logic                          r_out_valid, n_out_valid;
    logic                          r_skid_valid, n_skid_valid;
    t_out_item                     r_out_data, n_out_data;
    t_out_item                     r_skid_data, n_skid_data;

    assign w_en = !r_skid_valid;

    mlp_hid_mac u_hid_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_hx_valid),
        .o_x     (w_hx)
    );

    mlp_tanh #(.FRAC(HID_FRAC)) u_hid_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_hx_valid),
        .i_x     (w_hx),
        .o_valid (w_hy_valid),
        .o_y     (w_hy)
    );

    mlp_out_mac u_out_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_hy_valid),
        .i_h     (w_hy),
        .o_valid (w_ox_valid),
        .o_x     (w_ox)
    );

    mlp_tanh #(.FRAC(OUT_FRAC_BITS)) u_out_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ox_valid),
        .i_x     (w_ox),
        .o_valid (w_pipe_valid),
        .o_y     (w_oy)
    );

    // 1.0 does not fit 16 bits at 15 or 16 fraction bits
    for (genvar l = 0; l < LANES; l++) begin : g_sat
        logic signed [31:0] w_y32;
        assign w_y32    = 32'(w_oy[l]);
        assign w_sat[l] = (w_y32 > 32'sd32767)  ? 16'sh7FFF :
                          (w_y32 < -32'sd32768) ? 16'sh8000 : w_y32[15:0];
    end

    assign w_pipe_data.drive_out0 = w_sat[0];
    assign w_pipe_data.drive_out1 = w_sat[1];
    assign w_pipe_data.drive_out2 = w_sat[2];
    assign w_pipe_data.drive_out3 = w_sat[3];

    assign w_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_pipe_valid;
                n_out_data  = w_pipe_data;
            end
        end else if (w_pipe_valid && w_en) begin
            // result leaves the pipeline while the output is blocked
            n_skid_valid = 1'b1;
            n_skid_data  = w_pipe_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && r_out_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid register did not drain after output transfer");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pipe_valid && w_en && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("result leaving pipeline was not parked in skid register");

endmodule

>>> rtl/mlp_hid_mac.sv
module mlp_hid_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  mlp_pkg::t_in_item i_data,
    output logic              o_valid,
    output mlp_pkg::t_x_vec   o_x
);
    import mlp_pkg::*;

    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    logic [2:0]                   r_v;
    logic [22:0]                  r_q10;
    logic signed [ANG_TERM_W-1:0] r_ang;
    logic [57:0]                  w_dprod;
    logic signed [24:0]           w_in_dist;

    // low 16 bits of distance*65536+5 are just 5
    assign w_dprod = 58'({i_data.distance_cm, 16'd5}) * 58'(RECIP10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q10 <= w_dprod[57:35];
            r_ang <= ANG_TAB[i_data.servo_angle];
        end
    end

    assign w_in_dist = 25'sd65536 - $signed({2'b00, r_q10});

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [44:0]    r_p1;
        logic signed [37:0]    r_p2;
        logic signed [46:0]    w_s;
        logic signed [X_W-1:0] r_x;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p1 <= 45'(HID_W[1][l]) * 45'(w_in_dist);
                r_p2 <= 38'(HID_W[2][l]) * 38'(r_ang);
                r_x  <= X_W'(w_s >>> 16);
            end
        end

        // bias weight times 1.0, plus the rounding half
        assign w_s = 47'($signed({HID_W[0][l], 16'd0})) + 47'(r_p1) + 47'(r_p2)
                   + 47'sd32768;
        assign o_x[l] = r_x;
    end

    assign o_valid = r_v[2];

endmodule

>>> rtl/mlp_tanh.sv
module mlp_tanh #(
    parameter int FRAC = mlp_pkg::HID_FRAC
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  mlp_pkg::t_x_vec       i_x,
    output logic                  o_valid,
    output logic signed [FRAC+1:0] o_y [mlp_pkg::LANES]
);
    import mlp_pkg::*;

    localparam int QB  = FRAC + 1;
    localparam int NW  = 32 + FRAC;
    localparam int LAT = 16 + QB;
    localparam logic [31:0] DIV3 = 32'hAAAA_AAAB;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    logic [LAT-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_v[LAT-1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [31:0]     w_a;
        logic            w_sat;
        logic [LAT-2:0]  r_sat_l;
        logic [LAT-2:0]  r_neg_l;
        logic [25:0]     r_t_s1, r_t_s2, r_t_s3, r_t_s4, r_t_s5;
        logic [21:0]     r_t2_s2, r_t2_s3, r_t2_s4, r_t2_s5;
        logic [17:0]     r_t3_s3;
        logic [13:0]     r_t4_s4;
        logic [15:0]     r_d6_s4, r_d6_s5;
        logic [9:0]      r_d24_s5;
        logic [51:0]     w_p2;
        logic [47:0]     w_p3;
        logic [43:0]     w_p4;
        logic [48:0]     w_m6;
        logic [42:0]     w_m24;
        logic [31:0]     w_e0;
        logic [30:0]     r_e [9];
        logic [61:0]     w_sq [8];
        logic [31:0]     w_den;
        logic [30:0]     w_one_m_e;
        logic [NW-1:0]   w_n;
        logic [31:0]     r_den;
        logic [NW-1:0]   r_n;
        logic [31:0]     w_rin [QB];
        logic [QB-1:0]   w_qin [QB];
        logic [31:0]     w_din [QB];
        logic [NW-1:0]   w_nin [QB];
        logic [31:0]     w_tr [QB];
        logic [QB-1:0]   w_ge;
        logic [31:0]     w_rout [QB];
        logic [QB-1:0]   w_qout [QB];
        logic [31:0]     r_rem [QB];
        logic [QB-1:0]   r_q [QB];
        logic [31:0]     r_dd [QB];
        logic [NW-1:0]   r_nn [QB];
        logic [QB-1:0]   w_mag;
        logic signed [FRAC+1:0] r_y;

        assign w_a   = i_x[l][X_W-1] ? 32'(-i_x[l]) : 32'(i_x[l]);
        assign w_sat = w_a >= 32'h0008_0000;

        // t = 2a/256 in Q.30, powers truncated
        assign w_p2  = 52'(r_t_s1) * 52'(r_t_s1);
        assign w_p3  = 48'(r_t2_s2) * 48'(r_t_s2);
        assign w_p4  = 44'(r_t3_s3) * 44'(r_t_s3);
        assign w_m6  = 49'(r_t3_s3[17:1]) * 49'(DIV3);
        assign w_m24 = 43'(r_t4_s4[13:3]) * 43'(DIV3);
        assign w_e0  = 32'(ONE_Q30) - 32'(r_t_s5) + 32'(r_t2_s5 >> 1)
                     - 32'(r_d6_s5) + 32'(r_d24_s5);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sat_l <= '0;
                r_neg_l <= '0;
            end else if (i_en) begin
                r_sat_l <= {r_sat_l[LAT-3:0], w_sat};
                r_neg_l <= {r_neg_l[LAT-3:0], i_x[l][X_W-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t_s1   <= {w_a[18:0], 7'd0};
                r_t_s2   <= r_t_s1;
                r_t2_s2  <= w_p2[51:30];
                r_t_s3   <= r_t_s2;
                r_t2_s3  <= r_t2_s2;
                r_t3_s3  <= w_p3[47:30];
                r_t_s4   <= r_t_s3;
                r_t2_s4  <= r_t2_s3;
                r_t4_s4  <= w_p4[43:30];
                r_d6_s4  <= w_m6[48:33];
                r_t_s5   <= r_t_s4;
                r_t2_s5  <= r_t2_s4;
                r_d6_s5  <= r_d6_s4;
                r_d24_s5 <= w_m24[42:33];
                r_e[0]   <= w_e0[30:0];
                for (int k = 0; k < 8; k++) begin
                    r_e[k+1] <= w_sq[k][60:30];
                end
                r_den <= w_den;
                r_n   <= w_n;
                for (int j = 0; j < QB; j++) begin
                    r_rem[j] <= w_rout[j];
                    r_q[j]   <= w_qout[j];
                    r_dd[j]  <= w_din[j];
                    r_nn[j]  <= w_nin[j];
                end
                r_y <= r_neg_l[LAT-2] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
            end
        end

        // eight squarings, one per stage
        always_comb begin
            for (int k = 0; k < 8; k++) begin
                w_sq[k] = 62'(r_e[k]) * 62'(r_e[k]);
            end
        end

        // round((1-e)/(1+e)) as floor((num + den/2) / den)
        assign w_den     = 32'(ONE_Q30) + 32'(r_e[8]);
        assign w_one_m_e = ONE_Q30 - r_e[8];
        assign w_n       = (NW'(w_one_m_e) << FRAC) + NW'(w_den >> 1);

        // restoring divider, one quotient bit per stage
        always_comb begin
            w_rin[0] = 32'(r_n >> QB);
            w_qin[0] = '0;
            w_din[0] = r_den;
            w_nin[0] = r_n;
            for (int j = 1; j < QB; j++) begin
                w_rin[j] = r_rem[j-1];
                w_qin[j] = r_q[j-1];
                w_din[j] = r_dd[j-1];
                w_nin[j] = r_nn[j-1];
            end
            for (int j = 0; j < QB; j++) begin
                w_tr[j]   = {w_rin[j][30:0], w_nin[j][QB-1-j]};
                w_ge[j]   = w_tr[j] >= w_din[j];
                w_rout[j] = w_ge[j] ? w_tr[j] - w_din[j] : w_tr[j];
                w_qout[j] = w_qin[j];
                w_qout[j][QB-1-j] = w_ge[j];
            end
        end

        assign w_mag   = r_sat_l[LAT-2] ? (QB'(1) << FRAC) : r_q[QB-1];
        assign o_y[l]  = r_y;
    end

endmodule

>>> rtl/mlp_out_mac.sv
module mlp_out_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [mlp_pkg::H_W-1:0] i_h [mlp_pkg::LANES],
    output logic                            o_valid,
    output mlp_pkg::t_x_vec                 o_x
);
    import mlp_pkg::*;

    logic [1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    assign o_valid = r_v[1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [37:0]    r_p [LANES];
        logic signed [39:0]    w_s;
        logic signed [X_W-1:0] r_x;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < LANES; j++) begin
                    r_p[j] <= 38'(i_h[j]) * 38'(OUT_WT[j][l]);
                end
                r_x <= X_W'(w_s >>> 16);
            end
        end

        assign w_s = 40'(r_p[0]) + 40'(r_p[1]) + 40'(r_p[2]) + 40'(r_p[3]) + 40'sd32768;
        assign o_x[l] = r_x;
    end

endmodule
